/* hw/rtl/mmpe_pkg.sv */
package mmpe_pkg;

	// Request codes
	localparam logic [1:0] REQ_DRAW     = 2'd0;
	localparam logic [1:0] REQ_LOAD     = 2'd1;
	localparam logic [1:0] REQ_FINALIZE = 2'd2;

	// Generator mode codes
	localparam logic [1:0] MODE_SPLITMIX = 2'd0;
	localparam logic [1:0] MODE_WYRAND   = 2'd1;
	localparam logic [1:0] MODE_LEHMER   = 2'd2;
	localparam logic [1:0] MODE_XORSHIFT = 2'd3;

	// Register byte addresses
	localparam logic [2:0] ADDR_MODE = 3'd0;

	// Mixing and step constants
	localparam logic [63:0] MURMUR_MUL_A = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MURMUR_MUL_B = 64'hc4ceb9fe1a85ec53;
	localparam logic [63:0] SPLIT_GAMMA  = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] SPLIT_MUL_A  = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] SPLIT_MUL_B  = 64'h94d049bb133111eb;
	localparam logic [63:0] WY_INCR      = 64'h60bee2bee120fc15;
	localparam logic [63:0] WY_MUL_A     = 64'ha3b195354a39b70d;
	localparam logic [63:0] WY_MUL_B     = 64'h1b03738712fad5c9;
	localparam logic [63:0] LEHMER_MUL   = 64'hda942042e4dd58b5;
	localparam logic [63:0] XS_OUT_MUL   = 64'hd989bcacc137dcd5;

	// Operation in flight
	typedef enum logic [2:0] {
		OP_MURMUR   = 3'd0,
		OP_SPLITMIX = 3'd1,
		OP_WYRAND   = 3'd2,
		OP_LEHMER   = 3'd3,
		OP_XORSHIFT = 3'd4
	} op_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_ACC  = 4'b0100,
		ST_POST = 4'b1000
	} fsm_t;

	// Multiplier constant for an operation and its pass
	function automatic logic [63:0] mul_const(input op_t op, input logic pass);
		logic [63:0] c;
		c = LEHMER_MUL;
		case (op)
			OP_MURMUR:   c = pass ? MURMUR_MUL_B : MURMUR_MUL_A;
			OP_SPLITMIX: c = pass ? SPLIT_MUL_B : SPLIT_MUL_A;
			OP_WYRAND:   c = pass ? WY_MUL_B : WY_MUL_A;
			OP_LEHMER:   c = LEHMER_MUL;
			OP_XORSHIFT: c = XS_OUT_MUL;
			default:     c = LEHMER_MUL;
		endcase
		return c;
	endfunction

endpackage

/* hw/rtl/multi_mode_prng_engine.sv */
// Multi-mode random engine with one 64-bit state word: draws with splitmix64, wyrand,
// lehmer64 or a truncated xorshift (mode register at address 0), loads the state, or
// murmur-finalizes an operand. Every 64x64 product is built on one shared 32x32
// multiplier, four partial products per pass, under a small sequencer. A load writes the
// state and returns nothing; lehmer64 and xorshift draws run one multiply pass, while
// splitmix64, wyrand and finalize run two. Each pass issues the four partial products,
// then goes through an accumulate step and a post-processing step. A new item is taken
// only when the sequencer is idle; a finished result waits in the output register
// meanwhile, and a stalled output holds the sequencer in post-processing until the
// register frees up.
module multi_mode_prng_engine (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [63:0] operand_value,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] random_value,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	mmpe_pkg::fsm_t fsm_q;
	mmpe_pkg::op_t  op_q;
	logic           pass_q;
	logic [1:0]     pp_q;
	logic [63:0]    gen_state_q;
	logic [1:0]     mode_q;
	logic [63:0]    a_q;
	logic [127:0]   acc_q;
	logic           acc_clr;
	logic [63:0]    prod_q;
	logic [1:0]     prod_sh_q;
	logic           prod_vld_q;
	logic [63:0]    res_q;
	logic           out_valid_q;

	logic           in_acc;
	logic           out_acc;
	logic [63:0]    cst;
	logic [31:0]    mul_a;
	logic [31:0]    mul_b;
	logic [63:0]    mul_p;
	logic [127:0]   prod_ext;
	logic [63:0]    lo;
	logic [63:0]    hi;
	logic [63:0]    s_split;
	logic [63:0]    s_wy;
	logic [63:0]    xs1;
	logic [63:0]    xs2;
	logic [63:0]    xs3;
	logic           last_pass;
	logic [63:0]    post_res;
	logic [63:0]    post_next_a;
	logic           finish_ok;

	// Handshakes
	assign in_stall     = (fsm_q != mmpe_pkg::ST_IDLE);
	assign in_acc       = in_valid && !in_stall;
	assign out_acc      = out_valid_q && !out_stall;
	assign out_valid    = out_valid_q;
	assign random_value = res_q;

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == mmpe_pkg::ADDR_MODE[2]) ? {30'd0, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mmpe_pkg::MODE_SPLITMIX;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == mmpe_pkg::ADDR_MODE[2]) begin
			mode_q <= pwdata[1:0];
		end
	end

	// Shared 32x32 multiplier: k0 al*bl, k1 al*bh, k2 ah*bl, k3 ah*bh
	assign cst   = mmpe_pkg::mul_const(op_q, pass_q);
	assign mul_a = pp_q[1] ? a_q[63:32] : a_q[31:0];
	assign mul_b = pp_q[0] ? cst[63:32] : cst[31:0];
	assign mul_p = 64'(mul_a) * 64'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_q <= 1'b0;
		end else begin
			prod_vld_q <= (fsm_q == mmpe_pkg::ST_MUL);
		end
	end

	always_ff @(posedge clk) begin
		prod_q    <= mul_p;
		prod_sh_q <= 2'(pp_q[1]) + 2'(pp_q[0]);
	end

	// Align registered partial product and accumulate
	always_comb begin
		case (prod_sh_q)
			2'd0:    prod_ext = {64'd0, prod_q};
			2'd1:    prod_ext = {32'd0, prod_q, 32'd0};
			2'd2:    prod_ext = {prod_q, 64'd0};
			default: prod_ext = 128'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc_clr) begin
			acc_q <= 128'd0;
		end else if (prod_vld_q) begin
			acc_q <= acc_q + prod_ext;
		end
	end

	assign lo = acc_q[63:0];
	assign hi = acc_q[127:64];

	// Pre-mix values taken at acceptance
	assign s_split = gen_state_q + mmpe_pkg::SPLIT_GAMMA;
	assign s_wy    = gen_state_q + mmpe_pkg::WY_INCR;
	assign xs1     = gen_state_q ^ (gen_state_q >> 11);
	assign xs2     = xs1 ^ (xs1 << 31);
	assign xs3     = xs2 ^ (xs2 >> 18);

	// Post-processing of a finished product
	always_comb begin
		last_pass   = 1'b1;
		post_res    = hi;
		post_next_a = lo;
		case (op_q)
			mmpe_pkg::OP_MURMUR: begin
				last_pass   = pass_q;
				post_res    = lo ^ (lo >> 33);
				post_next_a = lo ^ (lo >> 33);
			end
			mmpe_pkg::OP_SPLITMIX: begin
				last_pass   = pass_q;
				post_res    = lo ^ (lo >> 31);
				post_next_a = lo ^ (lo >> 27);
			end
			mmpe_pkg::OP_WYRAND: begin
				last_pass   = pass_q;
				post_res    = hi ^ lo;
				post_next_a = hi ^ lo;
			end
			mmpe_pkg::OP_LEHMER: begin
				post_res = hi;
			end
			mmpe_pkg::OP_XORSHIFT: begin
				post_res = {32'd0, lo[63:32]};
			end
			default: begin
				post_res = hi;
			end
		endcase
	end

	// Result register is free or being emptied this cycle
	assign finish_ok = !out_valid_q || !out_stall;

	assign acc_clr = (fsm_q == mmpe_pkg::ST_IDLE)
		|| (fsm_q == mmpe_pkg::ST_POST && !last_pass);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= mmpe_pkg::ST_IDLE;
			op_q        <= mmpe_pkg::OP_MURMUR;
			pass_q      <= 1'b0;
			pp_q        <= 2'd0;
			gen_state_q <= 64'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			case (fsm_q)
				mmpe_pkg::ST_IDLE: begin
					pass_q <= 1'b0;
					pp_q   <= 2'd0;
					if (in_acc) begin
						case (req_type)
							mmpe_pkg::REQ_LOAD: begin
								gen_state_q <= operand_value;
							end
							mmpe_pkg::REQ_FINALIZE: begin
								op_q  <= mmpe_pkg::OP_MURMUR;
								fsm_q <= mmpe_pkg::ST_MUL;
							end
							mmpe_pkg::REQ_DRAW: begin
								fsm_q <= mmpe_pkg::ST_MUL;
								case (mode_q)
									mmpe_pkg::MODE_SPLITMIX: begin
										op_q        <= mmpe_pkg::OP_SPLITMIX;
										gen_state_q <= s_split;
									end
									mmpe_pkg::MODE_WYRAND: begin
										op_q        <= mmpe_pkg::OP_WYRAND;
										gen_state_q <= s_wy;
									end
									mmpe_pkg::MODE_LEHMER: begin
										op_q <= mmpe_pkg::OP_LEHMER;
									end
									default: begin
										op_q        <= mmpe_pkg::OP_XORSHIFT;
										gen_state_q <= xs3;
									end
								endcase
							end
							default: begin
								// unused request code: dropped
							end
						endcase
					end
				end
				mmpe_pkg::ST_MUL: begin
					pp_q <= pp_q + 2'd1;
					if (pp_q == 2'd3) begin
						fsm_q <= mmpe_pkg::ST_ACC;
					end
				end
				mmpe_pkg::ST_ACC: begin
					fsm_q <= mmpe_pkg::ST_POST;
				end
				mmpe_pkg::ST_POST: begin
					if (!last_pass) begin
						pass_q <= 1'b1;
						fsm_q  <= mmpe_pkg::ST_MUL;
					end else if (finish_ok) begin
						if (op_q == mmpe_pkg::OP_LEHMER) begin
							gen_state_q <= lo;
						end
						out_valid_q <= 1'b1;
						fsm_q       <= mmpe_pkg::ST_IDLE;
					end
				end
				default: begin
					fsm_q <= mmpe_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Multiplier operand for the next pass; result capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			case (req_type)
				mmpe_pkg::REQ_FINALIZE: a_q <= operand_value ^ (operand_value >> 33);
				default: begin
					case (mode_q)
						mmpe_pkg::MODE_SPLITMIX: a_q <= s_split ^ (s_split >> 30);
						mmpe_pkg::MODE_WYRAND:   a_q <= s_wy;
						default:                 a_q <= gen_state_q;
					endcase
				end
			endcase
		end else if (fsm_q == mmpe_pkg::ST_POST && !last_pass) begin
			a_q <= post_next_a;
		end
		if (fsm_q == mmpe_pkg::ST_POST && last_pass && finish_ok) begin
			res_q <= post_res;
		end
	end

	// Checks
	a_mul_runs: assert property (@(posedge clk) disable iff (!arst_n)
		fsm_q == mmpe_pkg::ST_MUL |=>
			fsm_q == mmpe_pkg::ST_MUL || fsm_q == mmpe_pkg::ST_ACC)
		else $error("multiply pass left early");

	a_prod_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		prod_vld_q |-> fsm_q == mmpe_pkg::ST_MUL || fsm_q == mmpe_pkg::ST_ACC)
		else $error("partial product outside a pass");

	a_acc_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		fsm_q == mmpe_pkg::ST_ACC |-> pp_q == 2'd0)
		else $error("partial product counter not wrapped");

	a_second_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(pass_q && fsm_q != mmpe_pkg::ST_IDLE) |->
			op_q != mmpe_pkg::OP_LEHMER && op_q != mmpe_pkg::OP_XORSHIFT)
		else $error("second pass on a single-multiply operation");

	a_no_result_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("pending result dropped");

endmodule

/* tb/tb_multi_mode_prng_engine.sv */
module tb_multi_mode_prng_engine;

	localparam int          CYCLE_LIMIT   = 400000;
	localparam int          SETTLE_CYCLES = 20;
	localparam int          RAND_PHASES   = 8;
	localparam int          PHASE_ITEMS   = 62;
	localparam logic [2:0]  ADDR_UNMAPPED = 3'd4;
	localparam logic [1:0]  REQ_UNUSED    = 2'd3;
	localparam logic [63:0] ALL_ONES      = 64'hffff_ffff_ffff_ffff;
	localparam logic [63:0] TOP_BIT       = 64'h8000_0000_0000_0000;

	typedef struct {
		logic [1:0]  kind;
		logic [63:0] operand;
	} prng_req_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [63:0] operand_value;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] random_value;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	multi_mode_prng_engine u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.operand_value (operand_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.random_value  (random_value),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// testbench copy of the engine
	logic [63:0] prng_state;
	logic [1:0]  prng_mode;

	prng_req_t   req_queue[$];
	logic [63:0] expected_values[$];
	int          err_cnt;
	int          cycle_cnt;
	int          in_gap;
	int          out_gap;
	bit          in_quiet;
	bit          out_quiet;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [127:0] mul_wide(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p;
	endfunction

	function automatic logic [63:0] murmur_hash(input logic [63:0] v);
		logic [63:0] h;
		h = v ^ (v >> 33);
		h = h * mmpe_pkg::MURMUR_MUL_A;
		h = h ^ (h >> 33);
		h = h * mmpe_pkg::MURMUR_MUL_B;
		return h ^ (h >> 33);
	endfunction

	// advance the copy for one accepted item and queue the value it yields
	task automatic predict_request(input logic [1:0] kind, input logic [63:0] opv);
		logic [127:0] p;
		logic [63:0]  z;
		logic [63:0]  s;
		case (kind)
			mmpe_pkg::REQ_LOAD: begin
				prng_state = opv;
			end
			mmpe_pkg::REQ_FINALIZE: begin
				expected_values.push_back(murmur_hash(opv));
			end
			mmpe_pkg::REQ_DRAW: begin
				case (prng_mode)
					mmpe_pkg::MODE_SPLITMIX: begin
						prng_state = prng_state + mmpe_pkg::SPLIT_GAMMA;
						z = prng_state;
						z = (z ^ (z >> 30)) * mmpe_pkg::SPLIT_MUL_A;
						z = (z ^ (z >> 27)) * mmpe_pkg::SPLIT_MUL_B;
						expected_values.push_back(z ^ (z >> 31));
					end
					mmpe_pkg::MODE_WYRAND: begin
						prng_state = prng_state + mmpe_pkg::WY_INCR;
						p = mul_wide(prng_state, mmpe_pkg::WY_MUL_A);
						z = p[127:64] ^ p[63:0];
						p = mul_wide(z, mmpe_pkg::WY_MUL_B);
						expected_values.push_back(p[127:64] ^ p[63:0]);
					end
					mmpe_pkg::MODE_LEHMER: begin
						p = mul_wide(prng_state, mmpe_pkg::LEHMER_MUL);
						prng_state = p[63:0];
						expected_values.push_back(p[127:64]);
					end
					default: begin
						z = prng_state * mmpe_pkg::XS_OUT_MUL;
						s = prng_state;
						s = s ^ (s >> 11);
						s = s ^ (s << 31);
						s = s ^ (s >> 18);
						prng_state = s;
						expected_values.push_back({32'd0, z[63:32]});
					end
				endcase
			end
			default: ;
		endcase
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				predict_request(req_type, operand_value);
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_valid <= 1'b0;
					in_gap = in_gap - 1;
				end else if (req_queue.size() > 0) begin
					in_valid      <= 1'b1;
					req_type      <= req_queue[0].kind;
					operand_value <= req_queue[0].operand;
					void'(req_queue.pop_front());
					in_gap = in_quiet ? 0 : pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_values.size() == 0) begin
					$error("unexpected item: random_value %h", random_value);
					err_cnt++;
				end else begin
					if (random_value !== expected_values[0]) begin
						$error("random_value mismatch: expected %h, actual %h",
							expected_values[0], random_value);
						err_cnt++;
					end
					void'(expected_values.pop_front());
				end
			end
			if (out_gap == 0 && !out_quiet && $urandom_range(0, 3) == 0)
				out_gap = pick_gap();
			out_stall <= (out_gap != 0);
			if (out_gap != 0)
				out_gap = out_gap - 1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == mmpe_pkg::ADDR_MODE)
			prng_mode = data[1:0];
	endtask

	task automatic send(input logic [1:0] kind, input logic [63:0] opv);
		prng_req_t r;
		r.kind    = kind;
		r.operand = opv;
		req_queue.push_back(r);
	endtask

	// wait until every item is out and the engine has settled; sampled between
	// edges so that driver updates of the same edge are already visible
	task automatic drain();
		@(negedge clk);
		while (req_queue.size() != 0 || in_valid || expected_values.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [63:0] rand_operand();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 64'd0;
		if (r == 1)
			return ALL_ONES;
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [1:0] rand_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 68)
			return mmpe_pkg::REQ_DRAW;
		if (r < 82)
			return mmpe_pkg::REQ_LOAD;
		if (r < 97)
			return mmpe_pkg::REQ_FINALIZE;
		return REQ_UNUSED;
	endfunction

	// stimulus
	initial begin
		logic [1:0] mode;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		req_type      = mmpe_pkg::REQ_DRAW;
		operand_value = 64'd0;
		out_stall     = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = mmpe_pkg::ADDR_MODE;
		pwdata        = 32'd0;
		prng_state    = 64'd0;
		prng_mode     = mmpe_pkg::MODE_SPLITMIX;
		err_cnt       = 0;
		cycle_cnt     = 0;
		in_gap        = 0;
		out_gap       = 0;
		in_quiet      = 1'b1;
		out_quiet     = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: splitmix from reset, hash extremes, unused code
		send(mmpe_pkg::REQ_DRAW, ALL_ONES);
		send(mmpe_pkg::REQ_FINALIZE, 64'd0);
		send(mmpe_pkg::REQ_FINALIZE, ALL_ONES);
		send(REQ_UNUSED, {$urandom(), $urandom()});
		send(mmpe_pkg::REQ_DRAW, 64'd0);
		send(mmpe_pkg::REQ_LOAD, ALL_ONES);
		send(mmpe_pkg::REQ_DRAW, 64'd0);
		drain();

		// lehmer on zero state stays zero, then draws from all ones
		reg_write(mmpe_pkg::ADDR_MODE, {30'd0, mmpe_pkg::MODE_LEHMER});
		send(mmpe_pkg::REQ_LOAD, 64'd0);
		send(mmpe_pkg::REQ_DRAW, 64'd0);
		send(mmpe_pkg::REQ_LOAD, ALL_ONES);
		send(mmpe_pkg::REQ_DRAW, ALL_ONES);
		send(mmpe_pkg::REQ_DRAW, 64'd0);
		drain();

		// xorshift on zero state, then top bit only
		in_quiet  = 1'b0;
		out_quiet = 1'b0;
		reg_write(mmpe_pkg::ADDR_MODE, {30'h3fff_ffff, mmpe_pkg::MODE_XORSHIFT});
		send(mmpe_pkg::REQ_LOAD, 64'd0);
		send(mmpe_pkg::REQ_DRAW, 64'd0);
		send(mmpe_pkg::REQ_LOAD, TOP_BIT);
		send(mmpe_pkg::REQ_DRAW, 64'd0);
		send(mmpe_pkg::REQ_DRAW, 64'd0);
		drain();

		// wyrand, then a write to an unmapped register must not change the mode
		reg_write(mmpe_pkg::ADDR_MODE, {30'd0, mmpe_pkg::MODE_WYRAND});
		send(mmpe_pkg::REQ_LOAD, 64'd0);
		send(mmpe_pkg::REQ_DRAW, 64'd0);
		send(mmpe_pkg::REQ_LOAD, ALL_ONES);
		send(mmpe_pkg::REQ_DRAW, 64'd0);
		send(mmpe_pkg::REQ_FINALIZE, TOP_BIT);
		drain();
		reg_write(ADDR_UNMAPPED, {30'd0, mmpe_pkg::MODE_LEHMER});
		send(mmpe_pkg::REQ_DRAW, 64'd0);
		drain();

		// random phases, each under its own mode and idling pattern
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			mode      = (ph < 4) ? 2'(ph) : 2'($urandom_range(0, 3));
			in_quiet  = ($urandom_range(0, 3) == 0);
			out_quiet = ($urandom_range(0, 3) == 0);
			reg_write(mmpe_pkg::ADDR_MODE, {30'($urandom_range(0, 32'h3fff_ffff)), mode});
			if ($urandom_range(0, 2) == 0)
				reg_write(ADDR_UNMAPPED, $urandom());
			send(mmpe_pkg::REQ_LOAD, {$urandom(), $urandom()});
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send(rand_kind(), rand_operand());
				// sender holds off once until the engine has caught up
				if (ph == 2 && i == PHASE_ITEMS / 2)
					drain();
			end
			drain();
		end

		if (err_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
